// ===== rtl/sorted_priority_queue_macros.svh =====
// Assertion macros used by the priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority queue check failed");
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority queue check failed");
`else
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/spq_pkg.sv =====
// Package: sizes, beat types, codes and command struct for the priority queue.
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] job_id;
        logic [7:0] priority_req;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] popped_id;
        logic [7:0] popped_priority;
        logic [1:0] status;
        logic [4:0] entry_count;
    } t_out_beat;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
// Controller: sequences capture and execute, owns the output valid flag.
`default_nettype none

module spq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_stall,
    output spq_pkg::t_dp_cmd     o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/spq_datapath.sv =====
// Datapath: input register, row of compare-and-shift cells, count, result register.
`default_nettype none

module spq_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spq_pkg::t_dp_cmd  i_cmd,
    input  wire spq_pkg::t_in_beat i_in,
    output spq_pkg::t_out_beat     o_out
);
    import spq_pkg::*;

    t_in_beat   r_in;
    t_out_beat  r_out, n_out;
    logic [7:0] r_ids [DEPTH];
    logic [7:0] r_pri [DEPTH];
    logic [7:0] n_ids [DEPTH];
    logic [7:0] n_pri [DEPTH];
    logic [CNT_W-1:0] r_count, n_count;
    logic [DEPTH-1:0] keep;
    logic full, empty, do_write;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // cells that stay in front of the new job: valid and priority >= new one
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            keep[i] = (CNT_W'(i) < r_count) && (r_pri[i] >= r_in.priority_req);
        end
    end

    always_comb begin
        n_count  = r_count;
        do_write = 1'b0;
        n_out    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            n_ids[i] = r_ids[i];
            n_pri[i] = r_pri[i];
        end
        if (r_in.opcode == OP_INSERT) begin
            if (full) begin
                n_out.status = ST_FULL;
            end else begin
                do_write = 1'b1;
                n_count  = r_count + 1'b1;
                // cell 0: take the new job unless it stays
                if (!keep[0]) begin
                    n_ids[0] = r_in.job_id;
                    n_pri[0] = r_in.priority_req;
                end
                for (int i = 1; i < DEPTH; i++) begin
                    if (!keep[i]) begin
                        if (keep[i-1]) begin
                            n_ids[i] = r_in.job_id;
                            n_pri[i] = r_in.priority_req;
                        end else begin
                            n_ids[i] = r_ids[i-1];
                            n_pri[i] = r_pri[i-1];
                        end
                    end
                end
            end
        end else begin
            if (empty) begin
                n_out.status = ST_EMPTY;
            end else begin
                do_write              = 1'b1;
                n_count               = r_count - 1'b1;
                n_out.popped_id       = r_ids[0];
                n_out.popped_priority = r_pri[0];
                // advance every entry one place toward the head
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_ids[i] = r_ids[i+1];
                    n_pri[i] = r_pri[i+1];
                end
            end
        end
        n_out.entry_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
        if (i_cmd.execute && do_write) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_ids[i] <= n_ids[i];
                r_pri[i] <= n_pri[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of jobs, highest priority first, with a pop/insert input channel.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): a beat is an insert
// (job id and priority) or a pop. Inserts go behind every stored job of equal
// or greater priority, so equal priorities leave in arrival order.
// Output channel (o_out_valid / i_out_stall, payload o_out): exactly one beat
// per input beat, with the popped job (zero otherwise), a status code (ok,
// insert dropped because full, pop while empty) and the entry count after it.
// A result is registered in the execute step after its input beat is captured;
// that step waits while the previous result is still stalled.
// The controller captures an item, then executes it, and takes no new item until
// that execute step; the cell row updates in one execute step.
// The output register lets a new input beat be taken while a result waits.
// While the receiver stalls a finished result, the next item holds in its
// execute step, so the input stalls until that result is taken.
// Reset empties the queue and clears the output valid flag; the cell contents
// are not cleared, only entries below the count are ever read.
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire spq_pkg::t_in_beat i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output spq_pkg::t_out_beat     o_out
);
    import spq_pkg::*;

    t_dp_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    spq_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    `SPQ_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `SPQ_ASSERT_NXT(a_exec_gives_beat, i_clk, i_rst_n, cmd.execute, o_out_valid)
    `SPQ_ASSERT_IMP(a_full_count, i_clk, i_rst_n, o_out_valid && o_out.status == ST_FULL, o_out.entry_count == 5'(DEPTH))
    `SPQ_ASSERT_IMP(a_empty_count, i_clk, i_rst_n, o_out_valid && o_out.status == ST_EMPTY, o_out.entry_count == 5'd0)

endmodule

`default_nettype wire

// ===== bench/sorted_priority_queue_tb.sv =====
// Testbench for the sorted priority queue: directed and random job traffic checked against a predictor.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 150000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out;

    // predicted queue contents, highest priority at index 0
    logic [7:0] job_ids [DEPTH];
    logic [7:0] job_pris[DEPTH];
    int         job_count;

    t_out_beat  expected_results[$];
    int         err_count;
    int         cycle_count;
    int         in_gap_max;
    int         out_stall_max;
    int         hold_off_cycles;

    sorted_priority_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_beat apply_job_cmd(input t_in_beat b);
        t_out_beat r;
        int        pos;
        int        i;
        r = '0;
        r.status = ST_OK;
        if (b.opcode == OP_INSERT) begin
            if (job_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // go behind every entry of equal or higher priority
                pos = 0;
                while (pos < job_count && job_pris[pos] >= b.priority_req) pos++;
                for (i = job_count; i > pos; i--) begin
                    job_ids[i]  = job_ids[i - 1];
                    job_pris[i] = job_pris[i - 1];
                end
                job_ids[pos]  = b.job_id;
                job_pris[pos] = b.priority_req;
                job_count++;
            end
        end else begin
            if (job_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped_id       = job_ids[0];
                r.popped_priority = job_pris[0];
                for (i = 0; i + 1 < job_count; i++) begin
                    job_ids[i]  = job_ids[i + 1];
                    job_pris[i] = job_pris[i + 1];
                end
                job_count--;
            end
        end
        r.entry_count = 5'(job_count);
        return r;
    endfunction

    function automatic logic [7:0] pick_priority(input int mode);
        logic [7:0] p;
        case (mode)
            0: p = 8'($urandom_range(0, 3));
            1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: p = 8'($urandom_range(0, 255));
        endcase
        return p;
    endfunction

    // Offer one beat and record its prediction once it is taken.
    task automatic send_job_cmd(input t_in_beat b);
        int gap;
        gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_results.push_back(apply_job_cmd(b));
    endtask

    task automatic insert_job(input logic [7:0] id, input logic [7:0] pri);
        t_in_beat b;
        b.opcode       = OP_INSERT;
        b.job_id       = id;
        b.priority_req = pri;
        send_job_cmd(b);
    endtask

    // id and priority are don't-care on a pop; randomize them anyway
    task automatic pop_job();
        t_in_beat b;
        b.opcode       = OP_POP;
        b.job_id       = 8'($urandom_range(0, 255));
        b.priority_req = 8'($urandom_range(0, 255));
        send_job_cmd(b);
    endtask

    task automatic test_field_extremes();
        pop_job();
        insert_job(8'h00, 8'h00);
        insert_job(8'hFF, 8'hFF);
        insert_job(8'hA5, 8'h80);
        insert_job(8'h5A, 8'h80);
        insert_job(8'h3C, 8'h80);
        repeat (6) pop_job();
    endtask

    task automatic test_full_and_overflow();
        int i;
        for (i = 0; i < DEPTH; i++) insert_job(8'(i * 17 + 3), pick_priority(0));
        insert_job(8'hEE, 8'hFF);
        pop_job();
    endtask

    task automatic test_random_traffic(input int n_items);
        int i;
        int insert_pct;
        int pri_mode;
        insert_pct = 50;
        pri_mode   = 2;
        for (i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                // sweep the mix so the queue swings between full and empty
                case ((i / 40) % 3)
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                pri_mode = $urandom_range(0, 2);
                case ((i / 40) % 4)
                    0: begin in_gap_max = 13; out_stall_max = 13; end
                    1: begin in_gap_max = 0;  out_stall_max = 0;  end
                    2: begin in_gap_max = 0;  out_stall_max = 13; end
                    default: begin in_gap_max = 13; out_stall_max = 0; end
                endcase
            end
            if ($urandom_range(0, 99) < insert_pct)
                insert_job(8'($urandom_range(0, 255)), pick_priority(pri_mode));
            else
                pop_job();
        end
    endtask

    task automatic test_output_hold_off();
        int i;
        in_gap_max      = 0;
        out_stall_max   = 0;
        hold_off_cycles = 150;
        for (i = 0; i < 30; i++) begin
            if ($urandom_range(0, 99) < 70)
                insert_job(8'($urandom_range(0, 255)), pick_priority(2));
            else
                pop_job();
        end
    endtask

    // result side: stall for a drawn number of cycles, then take one beat
    initial begin
        int wait_cycles;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                wait_cycles     = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                wait_cycles = (out_stall_max > 0) ? $urandom_range(0, out_stall_max) : 0;
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_out);
                err_count++;
            end else begin
                exp_beat = expected_results.pop_front();
                if (o_out.popped_id !== exp_beat.popped_id) begin
                    $display("%0t: popped_id expected %h got %h",
                             $time, exp_beat.popped_id, o_out.popped_id);
                    err_count++;
                end
                if (o_out.popped_priority !== exp_beat.popped_priority) begin
                    $display("%0t: popped_priority expected %h got %h",
                             $time, exp_beat.popped_priority, o_out.popped_priority);
                    err_count++;
                end
                if (o_out.status !== exp_beat.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, exp_beat.status, o_out.status);
                    err_count++;
                end
                if (o_out.entry_count !== exp_beat.entry_count) begin
                    $display("%0t: entry_count expected %0d got %0d",
                             $time, exp_beat.entry_count, o_out.entry_count);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sorted_priority_queue test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in            = '0;
        i_out_stall     = 1'b0;
        job_count       = 0;
        err_count       = 0;
        cycle_count     = 0;
        in_gap_max      = 13;
        out_stall_max   = 13;
        hold_off_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_full_and_overflow();
        test_random_traffic(450);
        test_output_hold_off();
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("sorted_priority_queue test passed");
        else
            $display("sorted_priority_queue test failed");
        $finish;
    end

endmodule
